// ===== src/tcp_retrans_timewait_timer_top_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef TCP_RETRANS_TIMEWAIT_TIMER_TOP_ASSERT_SVH
`define TCP_RETRANS_TIMEWAIT_TIMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RTT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/rtt_pkg.sv =====
`default_nettype none

package rtt_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned TIMER_W = 42;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned RETRY_W = 4;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [19:0] TICK_STEP_RST = 20'd10000;
  localparam logic [23:0] TIMEWAIT_PERIOD_RST = 24'd2000000;
  localparam logic [23:0] RETRANS_INITIAL_RST = 24'd200000;
  localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;
  localparam logic [15:0] SEGMENT_SIZE_RST = 16'd1460;

  localparam logic [RETRY_W-1:0] RETRY_SAT = '1;

  typedef enum logic [2:0] {
    REG_TICK_STEP = 3'd0,
    REG_TIMEWAIT_PERIOD = 3'd1,
    REG_RETRANS_INITIAL = 3'd2,
    REG_RETRY_LIMIT = 3'd3,
    REG_SEGMENT_SIZE = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_TICK = 3'd0,
    ACT_ENQUEUE = 3'd1,
    ACT_ARM_TW = 3'd2,
    ACT_ARM_RT = 3'd3,
    ACT_RESTART_RT = 3'd4,
    ACT_DISARM_RT = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ALU_TIMER,
    ALU_SEQ,
    ALU_SHL
  } alu_op_t;

  typedef struct packed {
    logic [19:0] tick_step;
    logic [23:0] timewait_period;
    logic [23:0] retrans_initial;
    logic [3:0] retry_limit;
    logic [15:0] segment_size;
  } cfg_t;

  typedef struct packed {
    alu_op_t op;
    logic [TIMER_W-1:0] a;
    logic [TIMER_W-1:0] b;
    logic [RETRY_W-1:0] shamt;
  } alu_req_t;

  typedef struct packed {
    logic [TIMER_W-1:0] value;
    logic le;
  } alu_rsp_t;

  typedef struct packed {
    logic we_end;
    logic we_retry;
    logic [QIDX_W-1:0] addr;
    logic [SEQ_W-1:0] end_val;
    logic [RETRY_W-1:0] retry_val;
  } q_wr_t;

  typedef struct packed {
    logic close_now;
    logic retransmit;
    logic [31:0] retx_segment_end;
    logic [3:0] retx_count;
    logic send_reset;
    logic retrans_stopped;
    logic window_cut;
    logic [31:0] new_cwnd;
    logic [31:0] new_ssthresh;
    logic queue_overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== src/rtt_if.sv =====
`default_nettype none

interface rtt_cmd_if;
  logic valid;
  logic ready;
  logic [2:0] action;
  logic [31:0] segment_end;
  logic [31:0] ack_point;
  logic [31:0] cwnd_now;

  modport source (output valid, action, segment_end, ack_point, cwnd_now, input ready);
  modport sink (input valid, action, segment_end, ack_point, cwnd_now, output ready);
endinterface

interface rtt_rsp_if;
  logic valid;
  logic ready;
  logic close_now;
  logic retransmit;
  logic [31:0] retx_segment_end;
  logic [3:0] retx_count;
  logic send_reset;
  logic retrans_stopped;
  logic window_cut;
  logic [31:0] new_cwnd;
  logic [31:0] new_ssthresh;
  logic queue_overflow;

  modport source (output valid, close_now, retransmit, retx_segment_end, retx_count,
                  send_reset, retrans_stopped, window_cut, new_cwnd, new_ssthresh,
                  queue_overflow, input ready);
  modport sink (input valid, close_now, retransmit, retx_segment_end, retx_count,
                send_reset, retrans_stopped, window_cut, new_cwnd, new_ssthresh,
                queue_overflow, output ready);
endinterface

`default_nettype wire

// ===== src/rtt_alu.sv =====
`default_nettype none

// Shared subtract / compare / shift unit.
module rtt_alu (
  input  wire rtt_pkg::alu_req_t req,
  output rtt_pkg::alu_rsp_t rsp
);

  logic [rtt_pkg::TIMER_W-1:0] diff;
  logic [rtt_pkg::SEQ_W-1:0] seq_diff;

  assign diff = req.a - req.b;
  assign seq_diff = req.a[rtt_pkg::SEQ_W-1:0] - req.b[rtt_pkg::SEQ_W-1:0];

  always_comb begin
    rsp = '0;
    case (req.op)
      rtt_pkg::ALU_TIMER: begin
        rsp.value = diff;
        rsp.le = (req.a <= req.b);
      end
      rtt_pkg::ALU_SEQ: begin
        // wrapping sequence compare: a at or before b
        rsp.value = rtt_pkg::TIMER_W'(seq_diff);
        rsp.le = (seq_diff == '0) || seq_diff[rtt_pkg::SEQ_W-1];
      end
      rtt_pkg::ALU_SHL: begin
        rsp.value = req.a << req.shamt;
        rsp.le = 1'b0;
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rtt_queue.sv =====
`default_nettype none

// Pending segment store: end sequence numbers and retry counts.
module rtt_queue (
  input  wire logic clk,
  input  wire rtt_pkg::q_wr_t wr,
  input  wire logic [rtt_pkg::QIDX_W-1:0] rd_addr,
  output logic [rtt_pkg::SEQ_W-1:0] rd_end,
  output logic [rtt_pkg::RETRY_W-1:0] rd_retry
);

  logic [rtt_pkg::SEQ_W-1:0] ends_mem [rtt_pkg::QUEUE_DEPTH];
  logic [rtt_pkg::RETRY_W-1:0] retries_mem [rtt_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_end) begin
      ends_mem[wr.addr] <= wr.end_val;
    end
    if (wr.we_retry) begin
      retries_mem[wr.addr] <= wr.retry_val;
    end
    rd_end <= ends_mem[rd_addr];
    rd_retry <= retries_mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/rtt_regs.sv =====
`default_nettype none

// APB configuration registers.
module rtt_regs (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [rtt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rtt_pkg::DATA_W-1:0] pwdata,
  output logic [rtt_pkg::DATA_W-1:0] prdata,
  output logic pready,
  output rtt_pkg::cfg_t cfg
);

  rtt_pkg::reg_idx_t idx;
  logic wr_en;

  assign idx = rtt_pkg::reg_idx_t'(paddr[rtt_pkg::ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_step <= rtt_pkg::TICK_STEP_RST;
      cfg.timewait_period <= rtt_pkg::TIMEWAIT_PERIOD_RST;
      cfg.retrans_initial <= rtt_pkg::RETRANS_INITIAL_RST;
      cfg.retry_limit <= rtt_pkg::RETRY_LIMIT_RST;
      cfg.segment_size <= rtt_pkg::SEGMENT_SIZE_RST;
    end else if (wr_en) begin
      case (idx)
        rtt_pkg::REG_TICK_STEP: cfg.tick_step <= pwdata[19:0];
        rtt_pkg::REG_TIMEWAIT_PERIOD: cfg.timewait_period <= pwdata[23:0];
        rtt_pkg::REG_RETRANS_INITIAL: cfg.retrans_initial <= pwdata[23:0];
        rtt_pkg::REG_RETRY_LIMIT: cfg.retry_limit <= pwdata[3:0];
        rtt_pkg::REG_SEGMENT_SIZE: cfg.segment_size <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      rtt_pkg::REG_TICK_STEP: prdata = rtt_pkg::DATA_W'(cfg.tick_step);
      rtt_pkg::REG_TIMEWAIT_PERIOD: prdata = rtt_pkg::DATA_W'(cfg.timewait_period);
      rtt_pkg::REG_RETRANS_INITIAL: prdata = rtt_pkg::DATA_W'(cfg.retrans_initial);
      rtt_pkg::REG_RETRY_LIMIT: prdata = rtt_pkg::DATA_W'(cfg.retry_limit);
      rtt_pkg::REG_SEGMENT_SIZE: prdata = rtt_pkg::DATA_W'(cfg.segment_size);
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tcp_retrans_timewait_timer_top.sv =====
// An item is taken in S_IDLE and runs S_EXEC, then S_DONE; a tick also passes S_RT, and a
// firing retransmission timer adds S_PWAIT and S_PCMP for each head examined, then S_RETRY
// unless the queue empties. One item at a time: ready again the cycle after its result is
// loaded into the output register, which waits while that register holds an untaken result.
// Reset (synchronous, rst high): timers disarmed and zeroed, queue empty, registers at
// defaults, no result pending; queue contents kept.
`default_nettype none

module tcp_retrans_timewait_timer_top (
  input  wire logic clk,
  input  wire logic rst,
  rtt_cmd_if.sink cmd,
  rtt_rsp_if.source rsp,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [rtt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [rtt_pkg::DATA_W-1:0] pwdata,
  output logic [rtt_pkg::DATA_W-1:0] prdata,
  output logic pready
);

  // Sequencer steps:
  //   S_IDLE  wait for an item
  //   S_EXEC  run non-tick actions; on a tick lower the time-wait timer
  //   S_RT    lower the retransmission timer
  //   S_PWAIT wait for the head entry to come out of the queue memory
  //   S_PCMP  stop the timer on an empty queue; else compare the head against the ack point, drop it if acknowledged
  //   S_RETRY reset or retransmit the head and back off the timeout
  //   S_DONE  hand the result to the output register
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RT,
    S_PWAIT,
    S_PCMP,
    S_RETRY,
    S_DONE
  } state_t;

  state_t state;

  rtt_pkg::cfg_t cfg;
  rtt_pkg::alu_req_t alu_req;
  rtt_pkg::alu_rsp_t alu_rsp;
  rtt_pkg::q_wr_t q_wr;

  // latched item
  rtt_pkg::action_t act;
  logic [31:0] seg_end;
  logic [31:0] ack;
  logic [31:0] cwnd;

  // timer and queue state
  logic [rtt_pkg::TIMER_W-1:0] timewait_left;
  logic timewait_armed;
  logic [rtt_pkg::TIMER_W-1:0] retrans_left;
  logic retrans_armed;
  logic [rtt_pkg::QIDX_W-1:0] queue_head;
  logic [rtt_pkg::QCNT_W-1:0] queue_count;

  logic [rtt_pkg::SEQ_W-1:0] rd_end;
  logic [rtt_pkg::RETRY_W-1:0] rd_retry;

  rtt_pkg::res_t res;
  rtt_pkg::res_t out_res;
  logic out_valid;

  logic queue_full;
  logic [rtt_pkg::QIDX_W:0] tail_sum;
  logic [rtt_pkg::QIDX_W-1:0] tail;
  logic [rtt_pkg::QIDX_W-1:0] head_next;
  logic over_limit;
  logic [rtt_pkg::RETRY_W-1:0] tries_next;

  rtt_regs u_regs (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cfg(cfg)
  );

  rtt_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  rtt_queue u_queue (
    .clk(clk),
    .wr(q_wr),
    .rd_addr(queue_head),
    .rd_end(rd_end),
    .rd_retry(rd_retry)
  );

  assign queue_full = (queue_count >= rtt_pkg::QCNT_W'(rtt_pkg::QUEUE_DEPTH));

  // Tail slot: head plus count, wrapped once around the ring.
  assign tail_sum = (rtt_pkg::QIDX_W+1)'(queue_head) + (rtt_pkg::QIDX_W+1)'(queue_count);
  assign tail = (tail_sum >= (rtt_pkg::QIDX_W+1)'(rtt_pkg::QUEUE_DEPTH)) ?
                rtt_pkg::QIDX_W'(tail_sum - (rtt_pkg::QIDX_W+1)'(rtt_pkg::QUEUE_DEPTH)) :
                rtt_pkg::QIDX_W'(tail_sum);

  assign head_next = (queue_head == rtt_pkg::QIDX_W'(rtt_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : queue_head + 1'b1;

  // A saturated count is over the limit whatever the limit says.
  assign over_limit = (rd_retry > cfg.retry_limit) || (rd_retry == rtt_pkg::RETRY_SAT);
  assign tries_next = rd_retry + 1'b1;

  // Route operands into the shared ALU for the current step.
  always_comb begin
    alu_req = '0;
    alu_req.op = rtt_pkg::ALU_TIMER;
    case (state)
      S_EXEC: begin
        alu_req.a = timewait_left;
        alu_req.b = rtt_pkg::TIMER_W'(cfg.tick_step);
      end
      S_RT: begin
        alu_req.a = retrans_left;
        alu_req.b = rtt_pkg::TIMER_W'(cfg.tick_step);
      end
      S_PCMP: begin
        alu_req.op = rtt_pkg::ALU_SEQ;
        alu_req.a = rtt_pkg::TIMER_W'(rd_end);
        alu_req.b = rtt_pkg::TIMER_W'(ack);
      end
      S_RETRY: begin
        alu_req.op = rtt_pkg::ALU_SHL;
        alu_req.a = rtt_pkg::TIMER_W'(cfg.retrans_initial);
        alu_req.shamt = tries_next;
      end
      default: begin
      end
    endcase
  end

  // Queue writes: new entry at the tail, bumped retry count at the head.
  always_comb begin
    q_wr = '0;
    if (state == S_EXEC && act == rtt_pkg::ACT_ENQUEUE && !queue_full) begin
      q_wr.we_end = 1'b1;
      q_wr.we_retry = 1'b1;
      q_wr.addr = tail;
      q_wr.end_val = seg_end;
      q_wr.retry_val = '0;
    end else if (state == S_RETRY && !over_limit) begin
      q_wr.we_retry = 1'b1;
      q_wr.addr = queue_head;
      q_wr.retry_val = tries_next;
    end
  end

  assign cmd.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      timewait_left <= '0;
      timewait_armed <= 1'b0;
      retrans_left <= '0;
      retrans_armed <= 1'b0;
      queue_head <= '0;
      queue_count <= '0;
      out_valid <= 1'b0;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && rsp.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act <= rtt_pkg::action_t'(cmd.action);
            seg_end <= cmd.segment_end;
            ack <= cmd.ack_point;
            cwnd <= cmd.cwnd_now;
            res <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= (act == rtt_pkg::ACT_TICK) ? S_RT : S_DONE;
          case (act)
            rtt_pkg::ACT_TICK: begin
              if (timewait_armed) begin
                if (alu_rsp.le) begin
                  timewait_left <= '0;
                  timewait_armed <= 1'b0;
                  res.close_now <= 1'b1;
                end else begin
                  timewait_left <= alu_rsp.value;
                end
              end
            end
            rtt_pkg::ACT_ENQUEUE: begin
              if (queue_full) begin
                res.queue_overflow <= 1'b1;
              end else begin
                queue_count <= queue_count + 1'b1;
              end
            end
            rtt_pkg::ACT_ARM_TW: begin
              timewait_left <= rtt_pkg::TIMER_W'(cfg.timewait_period);
              timewait_armed <= 1'b1;
            end
            rtt_pkg::ACT_ARM_RT: begin
              if (!retrans_armed) begin
                retrans_armed <= 1'b1;
                retrans_left <= rtt_pkg::TIMER_W'(cfg.retrans_initial);
              end
            end
            rtt_pkg::ACT_RESTART_RT: begin
              if (retrans_armed) begin
                retrans_left <= rtt_pkg::TIMER_W'(cfg.retrans_initial);
              end
            end
            rtt_pkg::ACT_DISARM_RT: begin
              if (retrans_armed) begin
                retrans_armed <= 1'b0;
                res.retrans_stopped <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_RT: begin
          if (retrans_armed && alu_rsp.le) begin
            retrans_left <= '0;
            state <= S_PWAIT;
          end else begin
            if (retrans_armed) begin
              retrans_left <= alu_rsp.value;
            end
            state <= S_DONE;
          end
        end
        S_PWAIT: begin
          state <= S_PCMP;
        end
        S_PCMP: begin
          if (queue_count == '0) begin
            // nothing left to resend: stop the timer
            retrans_armed <= 1'b0;
            res.retrans_stopped <= 1'b1;
            state <= S_DONE;
          end else if (alu_rsp.le) begin
            // head acknowledged: drop it and fetch the next one
            queue_head <= head_next;
            queue_count <= queue_count - 1'b1;
            state <= S_PWAIT;
          end else begin
            state <= S_RETRY;
          end
        end
        S_RETRY: begin
          if (over_limit) begin
            res.send_reset <= 1'b1;
            res.retrans_stopped <= 1'b1;
            retrans_armed <= 1'b0;
          end else begin
            retrans_left <= alu_rsp.value;
            res.retransmit <= 1'b1;
            res.retx_segment_end <= rd_end;
            res.retx_count <= tries_next;
            res.window_cut <= 1'b1;
            res.new_cwnd <= 32'(cfg.segment_size);
            res.new_ssthresh <= {1'b0, cwnd[31:1]};
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_res <= res;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.close_now = out_res.close_now;
  assign rsp.retransmit = out_res.retransmit;
  assign rsp.retx_segment_end = out_res.retx_segment_end;
  assign rsp.retx_count = out_res.retx_count;
  assign rsp.send_reset = out_res.send_reset;
  assign rsp.retrans_stopped = out_res.retrans_stopped;
  assign rsp.window_cut = out_res.window_cut;
  assign rsp.new_cwnd = out_res.new_cwnd;
  assign rsp.new_ssthresh = out_res.new_ssthresh;
  assign rsp.queue_overflow = out_res.queue_overflow;

endmodule

`default_nettype wire

// ===== src/rtt_checker.sv =====
`default_nettype none

`include "tcp_retrans_timewait_timer_top_assert.svh"

module rtt_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic cmd_valid,
  input wire logic cmd_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic rsp_retransmit,
  input wire logic [3:0] rsp_retx_count,
  input wire logic rsp_send_reset,
  input wire logic rsp_retrans_stopped,
  input wire logic rsp_window_cut
);

  // a result waiting at the output stays there until taken
  `RTT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "result dropped before taken")

  // the sequencer is busy right after taking an item
  `RTT_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "ready right after accept")

  // a retransmission carries a window cut and a nonzero count, never a reset
  `RTT_ASSERT_SAME(a_retx_shape, clk, rst, rsp_valid && rsp_retransmit, rsp_window_cut && !rsp_send_reset && rsp_retx_count != 4'd0, "malformed retransmit")

  // a reset request always stops the retransmission timer
  `RTT_ASSERT_SAME(a_reset_stops, clk, rst, rsp_valid && rsp_send_reset, rsp_retrans_stopped && !rsp_window_cut, "reset without stop")

endmodule

bind tcp_retrans_timewait_timer_top rtt_checker u_rtt_checker (
  .clk(clk),
  .rst(rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_retransmit(rsp.retransmit),
  .rsp_retx_count(rsp.retx_count),
  .rsp_send_reset(rsp.send_reset),
  .rsp_retrans_stopped(rsp.retrans_stopped),
  .rsp_window_cut(rsp.window_cut)
);

`default_nettype wire
